/* design/fsla_pkg.sv */
// fsla_pkg: shared constants, codes, state and handshake types for the slot allocator
// used by fsla_ctrl, fsla_dp and fixed_slot_free_list_allocator; no dependencies
`default_nettype none

package fsla_pkg;

   // defaults for the top-level parameters
   localparam int MAX_SLOTS_DEF = 256;
   localparam int ADDR_BITS_DEF = 32;

   // fixed field widths
   localparam int OBJ_ADDR_W  = 32;
   localparam int SLOT_NUM_W  = 8;
   localparam int FREE_W      = 9;
   localparam int STATUS_W    = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int BASE_W      = 32;
   localparam int COUNT_W     = 9;
   localparam int OBJ_W       = 13;
   localparam int ALIGN_W     = 4;

   // stride: max(object, 8) rounded up to an alignment of at most 4096 bytes fits 14 bits
   localparam int STRIDE_W  = 14;
   localparam int MIN_OBJ   = 8;
   localparam int MAX_ALIGN = 12;

   // register reset values
   localparam logic [BASE_W-1:0]  BASE_RST  = '0;
   localparam logic [COUNT_W-1:0] COUNT_RST = 9'd256;
   localparam logic [OBJ_W-1:0]   OBJ_RST   = 13'd8;
   localparam logic [ALIGN_W-1:0] ALIGN_RST = 4'd3;

   // request function codes
   localparam logic FUNC_TAKE = 1'b0;
   localparam logic FUNC_GIVE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_ADDRESS = 2'd0,
      CSR_SLOT_COUNT   = 2'd1,
      CSR_OBJECT_BYTES = 2'd2,
      CSR_ALIGN_LOG2   = 2'd3
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BOUNDS   = 3'd2,
      ST_ALIGN    = 3'd3,
      ST_NOTALLOC = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_TAKE_CHK,
      S_TAKE_UPD,
      S_GIVE_OFF,
      S_GIVE_CHK,
      S_DIV,
      S_GIVE_MARK,
      S_GIVE_UPD,
      S_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       sweep_restart;
      logic       sweep_step;
      logic       load;
      logic       take_start;
      logic       take_commit;
      logic       give_start;
      logic       div_init;
      logic       div_step;
      logic       idx_from_q;
      logic       give_commit;
      logic       status_we;
      status_type status;
      logic       emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;
      logic take_empty;
      logic out_of_bounds;
      logic div_last;
      logic rem_nonzero;
      logic mark_set;
      logic rsp_full;
   } sts_type;

endpackage

`default_nettype wire

/* design/fsla_ram.sv */
// fsla_ram: generic one-write one-read memory with registered read data
// no dependencies
`default_nettype none

module fsla_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/fsla_ctrl.sv */
// fsla_ctrl: sequencer for clearing pass, take, give-back and result hand-off
// depends on fsla_pkg
`default_nettype none

module fsla_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_func,
   input  wire logic             csr_we,
   input  wire fsla_pkg::sts_type sts,
   output fsla_pkg::cmd_type     cmd
);

   fsla_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsla_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = fsla_pkg::S_CLEAR;
      end else begin
         case (state_ff)
            fsla_pkg::S_CLEAR: begin
               if (sts.sweep_last) state_in = fsla_pkg::S_IDLE;
            end
            fsla_pkg::S_IDLE: begin
               if (req_valid) begin
                  if (req_func == fsla_pkg::FUNC_TAKE) state_in = fsla_pkg::S_TAKE_CHK;
                  else state_in = fsla_pkg::S_GIVE_OFF;
               end
            end
            fsla_pkg::S_TAKE_CHK: begin
               if (sts.take_empty) state_in = fsla_pkg::S_RESULT;
               else state_in = fsla_pkg::S_TAKE_UPD;
            end
            fsla_pkg::S_TAKE_UPD: state_in = fsla_pkg::S_RESULT;
            fsla_pkg::S_GIVE_OFF: state_in = fsla_pkg::S_GIVE_CHK;
            fsla_pkg::S_GIVE_CHK: begin
               if (sts.out_of_bounds) state_in = fsla_pkg::S_RESULT;
               else state_in = fsla_pkg::S_DIV;
            end
            fsla_pkg::S_DIV: begin
               if (sts.div_last) state_in = fsla_pkg::S_GIVE_MARK;
            end
            fsla_pkg::S_GIVE_MARK: begin
               if (sts.rem_nonzero) state_in = fsla_pkg::S_RESULT;
               else state_in = fsla_pkg::S_GIVE_UPD;
            end
            fsla_pkg::S_GIVE_UPD: state_in = fsla_pkg::S_RESULT;
            fsla_pkg::S_RESULT: begin
               if (!sts.rsp_full) state_in = fsla_pkg::S_IDLE;
            end
            default: state_in = fsla_pkg::S_CLEAR;
         endcase
      end
   end

   // outputs
   always_comb begin
      cmd               = '0;
      cmd.status        = fsla_pkg::ST_OK;
      req_ready         = 1'b0;
      cmd.sweep_restart = csr_we;
      case (state_ff)
         fsla_pkg::S_CLEAR: cmd.sweep_step = 1'b1;
         fsla_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         fsla_pkg::S_TAKE_CHK: begin
            if (sts.take_empty) begin
               cmd.status_we = 1'b1;
               cmd.status    = fsla_pkg::ST_EMPTY;
            end else begin
               cmd.take_start = 1'b1;
            end
         end
         fsla_pkg::S_TAKE_UPD: cmd.take_commit = 1'b1;
         fsla_pkg::S_GIVE_OFF: cmd.give_start = 1'b1;
         fsla_pkg::S_GIVE_CHK: begin
            if (sts.out_of_bounds) begin
               cmd.status_we = 1'b1;
               cmd.status    = fsla_pkg::ST_BOUNDS;
            end else begin
               cmd.div_init = 1'b1;
            end
         end
         fsla_pkg::S_DIV: cmd.div_step = 1'b1;
         fsla_pkg::S_GIVE_MARK: begin
            if (sts.rem_nonzero) begin
               cmd.status_we = 1'b1;
               cmd.status    = fsla_pkg::ST_ALIGN;
            end else begin
               cmd.idx_from_q = 1'b1;
            end
         end
         fsla_pkg::S_GIVE_UPD: begin
            if (sts.mark_set) begin
               cmd.give_commit = 1'b1;
            end else begin
               cmd.status_we = 1'b1;
               cmd.status    = fsla_pkg::ST_NOTALLOC;
            end
         end
         fsla_pkg::S_RESULT: cmd.emit = !sts.rsp_full;
         default: cmd.emit = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

/* design/fsla_dp.sv */
// fsla_dp: config registers, free list head and count, link and mark memories,
// stride arithmetic, shift-subtract divider and output register; uses fsla_pkg, fsla_ram
`default_nettype none

module fsla_dp #(
   parameter int MAX_SLOTS = fsla_pkg::MAX_SLOTS_DEF,
   parameter int ADDR_BITS = fsla_pkg::ADDR_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_func,
   input  wire logic [fsla_pkg::OBJ_ADDR_W-1:0]     req_object_address,
   input  wire logic                                csr_we,
   input  wire logic [fsla_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [fsla_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire fsla_pkg::cmd_type                   cmd,
   output fsla_pkg::sts_type                        sts,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [fsla_pkg::OBJ_ADDR_W-1:0]     rsp_slot_address,
   output logic      [fsla_pkg::SLOT_NUM_W-1:0]     rsp_slot_number,
   output logic      [fsla_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [fsla_pkg::FREE_W-1:0]         rsp_free_slots
);

   localparam int IDX_W   = $clog2(MAX_SLOTS);
   localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int STR_W   = fsla_pkg::STRIDE_W;
   localparam int PROD_W  = IDX_W + STR_W;
   localparam int LIM_W   = CNT_W + STR_W;
   localparam int CMP_W   = (ADDR_BITS > LIM_W) ? ADDR_BITS : LIM_W;
   localparam int NCMP_W  = (fsla_pkg::COUNT_W > CNT_W) ? fsla_pkg::COUNT_W : CNT_W;
   localparam int STEP_W  = $clog2(IDX_W) + 1;

   // configuration registers
   logic [fsla_pkg::BASE_W-1:0]  base_ff;
   logic [fsla_pkg::COUNT_W-1:0] count_ff;
   logic [fsla_pkg::OBJ_W-1:0]   object_ff;
   logic [fsla_pkg::ALIGN_W-1:0] align_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= fsla_pkg::BASE_RST;
         count_ff  <= fsla_pkg::COUNT_RST;
         object_ff <= fsla_pkg::OBJ_RST;
         align_ff  <= fsla_pkg::ALIGN_RST;
      end else if (csr_we) begin
         case (fsla_pkg::csr_index_type'(csr_index))
            fsla_pkg::CSR_BASE_ADDRESS: base_ff   <= fsla_pkg::BASE_W'(csr_wdata);
            fsla_pkg::CSR_SLOT_COUNT:   count_ff  <= fsla_pkg::COUNT_W'(csr_wdata);
            fsla_pkg::CSR_OBJECT_BYTES: object_ff <= fsla_pkg::OBJ_W'(csr_wdata);
            fsla_pkg::CSR_ALIGN_LOG2:   align_ff  <= fsla_pkg::ALIGN_W'(csr_wdata);
            default:                    base_ff   <= base_ff;
         endcase
      end
   end

   // effective slot count, saturated
   logic [CNT_W-1:0] n_eff;
   assign n_eff = (NCMP_W'(count_ff) > NCMP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                           : CNT_W'(count_ff);

   // stride, registered off the config registers
   logic [fsla_pkg::ALIGN_W-1:0] align_sat;
   logic [fsla_pkg::OBJ_W-1:0]   obj_min;
   logic [STR_W-1:0]             al_mask;
   logic [STR_W-1:0]             stride_in, stride_ff;

   assign align_sat = (align_ff > fsla_pkg::ALIGN_W'(fsla_pkg::MAX_ALIGN))
                      ? fsla_pkg::ALIGN_W'(fsla_pkg::MAX_ALIGN) : align_ff;
   assign obj_min   = (object_ff < fsla_pkg::OBJ_W'(fsla_pkg::MIN_OBJ))
                      ? fsla_pkg::OBJ_W'(fsla_pkg::MIN_OBJ) : object_ff;
   assign al_mask   = (STR_W'(1) << align_sat) - STR_W'(1);
   assign stride_in = (STR_W'(obj_min) + al_mask) & ~al_mask;

   always_ff @(posedge clock) begin
      stride_ff <= stride_in;
   end

   // free list state and clearing sweep
   logic [CNT_W-1:0] head_ff, free_ff;
   logic [IDX_W-1:0] sweep_ff;
   logic [CNT_W-1:0] sweep_nx;
   logic [CNT_W-1:0] sweep_link;
   logic [CNT_W-1:0] link_rdata;
   logic [0:0]       mark_rdata;
   logic [IDX_W-1:0] q_ff;

   assign sweep_nx   = CNT_W'(sweep_ff) + CNT_W'(1);
   assign sweep_link = (sweep_nx < n_eff) ? sweep_nx : CNT_W'(MAX_SLOTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         head_ff  <= '0;
         free_ff  <= '0;
      end else begin
         if (cmd.sweep_restart) sweep_ff <= '0;
         else if (cmd.sweep_step) sweep_ff <= sweep_ff + IDX_W'(1);

         if (cmd.sweep_step) begin
            head_ff <= '0;
            free_ff <= n_eff;
         end else if (cmd.take_commit) begin
            head_ff <= link_rdata;
            free_ff <= free_ff - CNT_W'(1);
         end else if (cmd.give_commit) begin
            head_ff <= CNT_W'(q_ff);
            free_ff <= free_ff + CNT_W'(1);
         end
      end
   end

   // result, product and divider registers
   logic [fsla_pkg::OBJ_ADDR_W-1:0] res_addr_ff;
   logic [IDX_W-1:0]                res_idx_ff;
   fsla_pkg::status_type            res_status_ff;
   logic [PROD_W-1:0]               prod_ff;
   logic [ADDR_BITS-1:0]            off_ff;
   logic [LIM_W-1:0]                lim_ff;
   logic [LIM_W-1:0]                rem_ff, dsh_ff;
   logic [STEP_W-1:0]               k_ff;

   logic [ADDR_BITS-1:0] take_sum;
   logic [ADDR_BITS-1:0] give_off;
   logic                 div_ge;
   logic [IDX_W:0]       q_shift;

   assign take_sum = ADDR_BITS'(base_ff) + ADDR_BITS'(prod_ff);
   assign give_off = ADDR_BITS'(res_addr_ff) - ADDR_BITS'(base_ff);
   assign div_ge   = rem_ff >= dsh_ff;
   assign q_shift  = {q_ff, div_ge};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_addr_ff   <= (req_func == fsla_pkg::FUNC_GIVE) ? req_object_address : '0;
         res_idx_ff    <= '0;
         res_status_ff <= fsla_pkg::ST_OK;
      end else begin
         if (cmd.take_start) res_idx_ff <= IDX_W'(head_ff);
         if (cmd.idx_from_q) res_idx_ff <= q_ff;
         if (cmd.take_commit) res_addr_ff <= fsla_pkg::OBJ_ADDR_W'(take_sum);
         if (cmd.status_we) res_status_ff <= cmd.status;
      end

      // index times stride for the slot address
      if (cmd.take_start) prod_ff <= PROD_W'(IDX_W'(head_ff)) * PROD_W'(stride_ff);

      // byte offset and pool limit
      if (cmd.give_start) begin
         off_ff <= give_off;
         lim_ff <= LIM_W'(n_eff) * LIM_W'(stride_ff);
      end

      // restoring division, one quotient bit per cycle, msb first
      if (cmd.div_init) begin
         rem_ff <= LIM_W'(off_ff);
         dsh_ff <= LIM_W'(stride_ff) << (IDX_W - 1);
         q_ff   <= '0;
         k_ff   <= STEP_W'(IDX_W - 1);
      end else if (cmd.div_step) begin
         if (div_ge) rem_ff <= rem_ff - dsh_ff;
         dsh_ff <= dsh_ff >> 1;
         q_ff   <= q_shift[IDX_W-1:0];
         k_ff   <= k_ff - STEP_W'(1);
      end
   end

   // link and allocation mark memories
   logic                link_we;
   logic [IDX_W-1:0]    link_waddr;
   logic [CNT_W-1:0]    link_wdata;
   logic                mark_we;
   logic [IDX_W-1:0]    mark_waddr;
   logic [0:0]          mark_wdata;

   assign link_we    = cmd.sweep_step | cmd.give_commit;
   assign link_waddr = cmd.sweep_step ? sweep_ff : q_ff;
   assign link_wdata = cmd.sweep_step ? sweep_link : head_ff;

   assign mark_we    = cmd.sweep_step | cmd.take_commit | cmd.give_commit;
   assign mark_waddr = cmd.sweep_step ? sweep_ff : (cmd.take_commit ? res_idx_ff : q_ff);
   assign mark_wdata = cmd.take_commit;

   fsla_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (IDX_W'(head_ff)),
      .rd_data (link_rdata)
   );

   fsla_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SLOTS)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_addr (q_ff),
      .rd_data (mark_rdata)
   );

   // output register
   logic                            rsp_valid_ff;
   logic [fsla_pkg::OBJ_ADDR_W-1:0] rsp_addr_ff;
   logic [fsla_pkg::SLOT_NUM_W-1:0] rsp_num_ff;
   logic [fsla_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [fsla_pkg::FREE_W-1:0]     rsp_free_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_num_ff    <= fsla_pkg::SLOT_NUM_W'(res_idx_ff);
         rsp_status_ff <= res_status_ff;
         rsp_free_ff   <= fsla_pkg::FREE_W'(free_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_address = rsp_addr_ff;
   assign rsp_slot_number  = rsp_num_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_free_slots   = rsp_free_ff;

   // status to the controller
   always_comb begin
      sts               = '0;
      sts.sweep_last    = sweep_ff == IDX_W'(MAX_SLOTS - 1);
      sts.take_empty    = (free_ff == '0) || (head_ff >= n_eff);
      sts.out_of_bounds = CMP_W'(off_ff) >= CMP_W'(lim_ff);
      sts.div_last      = k_ff == '0;
      sts.rem_nonzero   = rem_ff != '0;
      sts.mark_set      = mark_rdata[0];
      sts.rsp_full      = rsp_valid_ff & ~rsp_ready;
   end

endmodule

`default_nettype wire

/* design/fixed_slot_free_list_allocator.sv */
// fixed_slot_free_list_allocator: top level of the fixed-slot pool allocator
// instantiates fsla_ctrl and fsla_dp; depends on fsla_pkg
`default_nettype none

// channel     ports                               direction  transfer when
// ---------   ---------------------------------   ---------  -------------------------
// request     req_valid/req_ready, func, address  in         req_valid & req_ready
// response    rsp_valid/rsp_ready, addr/num/st/   out        rsp_valid & rsp_ready
//             free
// csr         csr_we, csr_index, csr_wdata        in         csr_we (no wait)
//
// one item at a time: a take passes the check and update states, a give-back the offset,
// bounds check, divider, mark check and update states; each ends in the result state, an
// error skipping ahead to it. the shift-subtract divider turns the byte offset into a
// slot index one quotient bit per cycle. after reset and after every csr write a clearing
// pass relinks the pool, one link/mark entry per cycle, req_ready low meanwhile.
// a finished item waits in the output register while the next request can be taken.

module fixed_slot_free_list_allocator #(
   parameter int MAX_SLOTS = fsla_pkg::MAX_SLOTS_DEF,
   parameter int ADDR_BITS = fsla_pkg::ADDR_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_func,
   input  wire logic [fsla_pkg::OBJ_ADDR_W-1:0]  req_object_address,
   // response
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [fsla_pkg::OBJ_ADDR_W-1:0]  rsp_slot_address,
   output logic      [fsla_pkg::SLOT_NUM_W-1:0]  rsp_slot_number,
   output logic      [fsla_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [fsla_pkg::FREE_W-1:0]      rsp_free_slots,
   // configuration
   input  wire logic                             csr_we,
   input  wire logic [fsla_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fsla_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // command and status between sequencer and datapath
   fsla_pkg::cmd_type cmd;
   fsla_pkg::sts_type sts;

   // sequencer: clearing pass, take and give-back steps, response hand-off
   fsla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .csr_we    (csr_we),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: registers, memories, address math, divider, output register
   fsla_dp #(
      .MAX_SLOTS (MAX_SLOTS),
      .ADDR_BITS (ADDR_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_func           (req_func),
      .req_object_address (req_object_address),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_slot_address   (rsp_slot_address),
      .rsp_slot_number    (rsp_slot_number),
      .rsp_status         (rsp_status),
      .rsp_free_slots     (rsp_free_slots)
   );

endmodule

`default_nettype wire

/* sim/fixed_slot_free_list_allocator_tb.sv */
// fixed_slot_free_list_allocator_tb: self-checking bench for the fixed-slot pool allocator
// drives take/give-back requests and csr writes, predicts every response in-bench
// depends on fsla_pkg and fixed_slot_free_list_allocator
`timescale 1ns / 100ps

module fixed_slot_free_list_allocator_tb;
   import fsla_pkg::*;

   localparam int MAX_SLOTS = MAX_SLOTS_DEF;

   // one request as the driver sends it
   typedef struct packed {
      logic                  func;
      logic [OBJ_ADDR_W-1:0] address;
   } pool_request_type;

   // one response as the allocator should return it
   typedef struct packed {
      logic [OBJ_ADDR_W-1:0] slot_address;
      logic [SLOT_NUM_W-1:0] slot_number;
      status_type            status;
      logic [FREE_W-1:0]     free_slots;
   } alloc_result_type;

   // clock, reset and block ports; the bench-driven ones are all known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_func = FUNC_TAKE;
   logic [OBJ_ADDR_W-1:0]  req_object_address = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [OBJ_ADDR_W-1:0]  rsp_slot_address;
   logic [SLOT_NUM_W-1:0]  rsp_slot_number;
   logic [STATUS_W-1:0]    rsp_status;
   logic [FREE_W-1:0]      rsp_free_slots;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BASE_ADDRESS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // requests waiting to be sent, responses waiting to come back
   pool_request_type requests_pending[$];
   alloc_result_type results_due[$];

   // idle chances in percent per cycle, changed between phases
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned mismatches = 0;

   // shadow of the pool: registers as written, then the free list itself
   logic [BASE_W-1:0]  pool_base;
   logic [COUNT_W-1:0] pool_count;
   logic [OBJ_W-1:0]   pool_obj_bytes;
   logic [ALIGN_W-1:0] pool_align;
   logic [8:0]         link_next [MAX_SLOTS];
   logic [8:0]         free_head;
   logic [8:0]         free_cnt;
   bit                 slot_taken [MAX_SLOTS];

   fixed_slot_free_list_allocator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_object_address (req_object_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_slot_address   (rsp_slot_address),
      .rsp_slot_number    (rsp_slot_number),
      .rsp_status         (rsp_status),
      .rsp_free_slots     (rsp_free_slots),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // counts above the array size saturate
   function automatic int unsigned live_slots();
      return (pool_count > MAX_SLOTS) ? MAX_SLOTS : int'(pool_count);
   endfunction

   // max(object, 8) rounded up to the alignment, which saturates at 4 KiB
   function automatic longint unsigned slot_stride();
      longint unsigned align_bytes, obj;
      align_bytes = 64'd1 << ((pool_align > MAX_ALIGN) ? MAX_ALIGN : pool_align);
      obj = (pool_obj_bytes < MIN_OBJ) ? MIN_OBJ : pool_obj_bytes;
      return (obj + align_bytes - 1) & ~(align_bytes - 1);
   endfunction

   // every slot free, linked in index order, the last one ends the list
   function automatic void relink_pool();
      int unsigned n;
      n = live_slots();
      for (int i = 0; i < MAX_SLOTS; i++) begin
         link_next[i] = (i + 1 < n) ? 9'(i + 1) : 9'(MAX_SLOTS);
         slot_taken[i] = 1'b0;
      end
      free_head = '0;
      free_cnt = 9'(n);
   endfunction

   function automatic void apply_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_BASE_ADDRESS: pool_base = value[BASE_W-1:0];
         CSR_SLOT_COUNT:   pool_count = value[COUNT_W-1:0];
         CSR_OBJECT_BYTES: pool_obj_bytes = value[OBJ_W-1:0];
         CSR_ALIGN_LOG2:   pool_align = value[ALIGN_W-1:0];
         default:          return;
      endcase
      relink_pool();
   endfunction

   // one accepted request: update the shadow pool and return the response it causes
   function automatic alloc_result_type serve_request(logic func,
                                                      logic [OBJ_ADDR_W-1:0] address);
      alloc_result_type r;
      logic [31:0]      offset;
      longint unsigned  stride;
      int unsigned      n, k;
      r = '0;
      r.status = ST_OK;
      stride = slot_stride();
      n = live_slots();
      if (func == FUNC_TAKE) begin
         if (free_cnt == 0 || free_head >= n) begin
            r.status = ST_EMPTY;
         end else begin
            k = free_head;
            r.slot_address = 32'(pool_base + k * stride);
            r.slot_number = k[7:0];
            free_head = link_next[k];
            free_cnt = free_cnt - 1'b1;
            slot_taken[k] = 1'b1;
         end
      end else begin
         // offset wraps modulo 2^32, so a wrapped slot address still maps back
         offset = address - pool_base;
         r.slot_address = address;
         if (longint'(offset) >= n * stride) begin
            r.status = ST_BOUNDS;
         end else if (offset % stride != 0) begin
            r.status = ST_ALIGN;
         end else begin
            k = int'(offset / stride);
            r.slot_number = k[7:0];
            if (!slot_taken[k]) begin
               r.status = ST_NOTALLOC;
            end else begin
               slot_taken[k] = 1'b0;
               link_next[k] = free_head;
               free_head = 9'(k);
               free_cnt = free_cnt + 1'b1;
            end
         end
      end
      r.free_slots = free_cnt;
      return r;
   endfunction

   function automatic void queue_request(logic func, logic [OBJ_ADDR_W-1:0] address);
      pool_request_type q;
      q.func = func;
      q.address = address;
      requests_pending.push_back(q);
   endfunction

   // random request steered by the shadow pool: mostly takes and give-backs of
   // slots that are out, plus free slots, misaligned, out-of-range and raw noise
   function automatic void queue_random_request();
      int unsigned     pick, n, k, start;
      longint unsigned stride;
      bit              found;
      n = live_slots();
      stride = slot_stride();
      pick = $urandom_range(99);
      k = (n == 0) ? 0 : $urandom_range(n - 1);
      if (pick < 45) begin
         queue_request(FUNC_TAKE, $urandom());
      end else if (pick < 80) begin
         found = 1'b0;
         start = $urandom_range(MAX_SLOTS - 1);
         for (int j = 0; j < MAX_SLOTS && !found; j++) begin
            if (slot_taken[(start + j) % MAX_SLOTS]) begin
               k = (start + j) % MAX_SLOTS;
               found = 1'b1;
            end
         end
         queue_request(FUNC_GIVE, 32'(pool_base + k * stride));
      end else if (pick < 87) begin
         queue_request(FUNC_GIVE, 32'(pool_base + k * stride));
      end else if (pick < 92) begin
         queue_request(FUNC_GIVE, 32'(pool_base + k * stride
                                      + $urandom_range(1, 32'(stride - 1))));
      end else if (pick < 96) begin
         // just past the top or just below the base
         if ($urandom_range(1))
            queue_request(FUNC_GIVE,
                          32'(pool_base + n * stride + $urandom_range(3) * stride));
         else
            queue_request(FUNC_GIVE, pool_base - $urandom_range(1, 64));
      end else begin
         queue_request(1'($urandom_range(1)), $urandom());
      end
   endfunction

   // csr writes happen only with the pool idle; each one restarts the clearing pass
   task automatic set_pool(logic [31:0] base_addr, logic [31:0] slots,
                           logic [31:0] obj_size, logic [31:0] align);
      logic [31:0] vals [4];
      vals = '{base_addr, slots, obj_size, align};
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= vals[i];
         apply_csr(csr_index_type'(i), vals[i]);
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // keep one request of lookahead so the driver can send back to back
   task automatic run_random(int unsigned total);
      repeat (total) begin
         @(negedge clock);
         while (requests_pending.size() != 0) @(negedge clock);
         queue_random_request();
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (requests_pending.size() != 0 || req_valid || results_due.size() != 0)
         @(negedge clock);
   endtask

   // request driver: the shadow pool is updated at each transfer
   always @(posedge clock) begin
      pool_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            results_due.push_back(serve_request(req_func, req_object_address));
         if (!req_valid || req_ready) begin
            if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = requests_pending.pop_front();
               req_valid <= 1'b1;
               req_func <= next_req.func;
               req_object_address <= next_req.address;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: each transfer is checked against the oldest expectation
   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("unexpected response transfer, slot_address %h", rsp_slot_address);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               if (rsp_slot_address !== want.slot_address) begin
                  $error("slot_address: expected %h, got %h",
                         want.slot_address, rsp_slot_address);
                  mismatches++;
               end
               if (rsp_slot_number !== want.slot_number) begin
                  $error("slot_number: expected %0d, got %0d",
                         want.slot_number, rsp_slot_number);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_free_slots !== want.free_slots) begin
                  $error("free_slots: expected %0d, got %0d",
                         want.free_slots, rsp_free_slots);
                  mismatches++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // stimulus sequence
   initial begin
      pool_base = BASE_RST;
      pool_count = COUNT_RST;
      pool_obj_bytes = OBJ_RST;
      pool_align = ALIGN_RST;
      relink_pool();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sender idles often, receiver stalls more
      send_idle_pct = 27;
      recv_idle_pct = 54;

      // reset setting: 256 slots of 8 bytes at address zero
      queue_request(FUNC_TAKE, 32'h0);
      queue_request(FUNC_TAKE, 32'hffff_ffff);
      queue_request(FUNC_GIVE, 32'h0);              // slot 0 back
      queue_request(FUNC_GIVE, 32'h0);              // already free
      queue_request(FUNC_GIVE, 32'hc);              // off the stride
      queue_request(FUNC_GIVE, 32'h800);            // first address past the pool
      queue_request(FUNC_GIVE, 32'hffff_ffff);      // far out, all ones
      queue_request(FUNC_TAKE, 32'h0);              // slot 0 again from the head
      run_random(120);
      wait_idle();

      // four slots straddling the top of the address space, object size zero
      set_pool(32'hffff_fff0, 4, 0, 0);
      repeat (5) queue_request(FUNC_TAKE, 32'h0);   // last one finds the pool empty
      queue_request(FUNC_GIVE, 32'h0000_0008);      // wrapped slot 3 back
      queue_request(FUNC_GIVE, 32'h0000_0010);      // one past the wrapped top
      queue_request(FUNC_GIVE, 32'hffff_ffe8);      // below the base
      queue_request(FUNC_GIVE, 32'hffff_fff4);      // inside slot 0, misaligned
      run_random(150);
      wait_idle();

      // no slots at all, largest object and alignment beyond the limit
      set_pool(32'h0000_1000, 0, 8191, 15);
      queue_request(FUNC_TAKE, 32'h0);
      queue_request(FUNC_GIVE, 32'h0000_1000);
      run_random(30);
      wait_idle();

      // the other way round: receiver mostly ready, sender idles more
      send_idle_pct = 54;
      recv_idle_pct = 27;

      // slot count above the array size saturates, 8 KiB stride
      set_pool(32'h8000_0000, 511, 8191, 15);
      queue_request(FUNC_GIVE, 32'h801f_e000);      // top slot, never taken
      run_random(150);
      wait_idle();

      // stride of 100 bytes, not a power of two, from an all-ones base
      set_pool(32'hffff_ffff, 37, 100, 0);
      run_random(200);
      wait_idle();

      // single slot, 13-byte object on a 4-byte alignment
      set_pool(32'h0000_4000, 1, 13, 2);
      run_random(100);
      wait_idle();

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;

      set_pool(32'h2345_6780, 256, 4096, 12);
      run_random(150);
      wait_idle();

      set_pool(32'h1000_0000, 200, 24, 4);
      run_random(100);
      wait_idle();

      // small object, alignment of 13 saturates to 4 KiB
      set_pool(32'h7fff_fff8, 3, 7, 13);
      run_random(100);
      wait_idle();

      // let any stray response show up
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("fixed_slot_free_list_allocator_tb passed");
      end else begin
         $display("fixed_slot_free_list_allocator_tb failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("fixed_slot_free_list_allocator_tb failed");
      $finish;
   end

endmodule
